[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the allocator.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/fpba_pkg.sv]
// Shared types and codes of the fit-policy block allocator.
// Depends on nothing; used by the interfaces and all modules.
package fpba_pkg;

    localparam int REQ_TYPE_W = 1;
    localparam int SLOT_W     = 3;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int BLK_CNT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    localparam logic [MODE_W-1:0]    FIT_MODE_RESET = MODE_FIRST;
    localparam logic [BLK_CNT_W-1:0] BLOCKS_RESET   = 4'd8;

    // Verdict of the shared compare unit for one table entry
    typedef struct packed {
        logic take;   // entry becomes the current pick
        logic stop;   // first fit found: end the search
    } fpba_cmp_t;

endpackage

[sv/fpba_in_if.sv]
// Input item channel of the allocator: valid, ready and request payload.
// Depends on fpba_pkg.
interface fpba_in_if;
    import fpba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [SLOT_W-1:0]     slot_index;
    logic [SIZE_W-1:0]     size_value;

    modport source (output valid, req_type, slot_index, size_value, input ready);
    modport sink   (input valid, req_type, slot_index, size_value, output ready);
endinterface

[sv/fpba_out_if.sv]
// Result item channel of the allocator: valid, ready and result payload.
// Depends on fpba_pkg.
interface fpba_out_if;
    import fpba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   chosen_block;
    logic [SIZE_W-1:0]   space_left;

    modport source (output valid, status, chosen_block, space_left, input ready);
    modport sink   (input valid, status, chosen_block, space_left, output ready);
endinterface

[sv/fpba_cfg_if.sv]
// Configuration write channel of the allocator: valid, ready, index, data.
// Depends on fpba_pkg.
interface fpba_cfg_if;
    import fpba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/fit_policy_block_allocator_unit.sv]
// Top level of the fit-policy block allocator: sequencer, table, registers.
// Depends on fpba_pkg, the fpba_*_if interfaces, fpba_fit_cmp, assert_macros.svh.
//
// Usage:
//   req  - input items. req_type 0 loads size_value into block slot_index;
//          req_type 1 asks for size_value units from the searched blocks.
//   rsp  - one result item per input item: status, chosen_block, space_left.
//   cfg  - register writes, always ready: index 0 fit_mode (0 first,
//          1 best, 2 worst fit, 3 acts as first), index 1 blocks_in_use.
// Timing:
//   A load goes from acceptance to the finish state and from there into the
//   output register. An allocation runs the scan, write and finish states:
//   the shared compare unit examines the entries in turn (blocks_in_use
//   saturated to NUM_BLOCKS; first fit stops at the first entry that fits),
//   one entry per cycle from the single read port of the table, then the
//   write state writes the chosen block back.
//   req.ready is high only while the sequencer is idle.
// Reset:
//   All table entries read as zero (per-entry valid bits), fit_mode 0,
//   blocks_in_use 8, no result pending.
// Stall:
//   A result holds in the output register while rsp.ready is low; the next
//   item is still taken and runs until its own result would overwrite it.
`include "assert_macros.svh"

module fit_policy_block_allocator_unit #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fpba_in_if.sink    req,
    fpba_out_if.source rsp,
    fpba_cfg_if.sink   cfg
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > BLK_CNT_W) ? CNT_W : BLK_CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Control state
    logic [1:0]            state_reg, state_next;
    logic [MODE_W-1:0]     fit_mode_reg;
    logic [BLK_CNT_W-1:0]  blocks_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;

    // Payload
    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]  rd_data_reg;
    logic                  rd_vld_reg;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_BITS-1:0]  pick_val_reg, pick_val_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_block_reg, res_block_next;
    logic [SIZE_W-1:0]     res_left_reg, res_left_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_block_reg;
    logic [SIZE_W-1:0]     out_left_reg;

    logic                  accept;
    logic                  publish;
    logic                  slot_in_range;
    logic [SIZE_BITS-1:0]  in_size;
    logic [SIZE_BITS-1:0]  entry_val;
    logic                  last_entry;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_BITS-1:0]  wr_data;
    logic [SIZE_BITS-1:0]  remain;
    logic [CMP_W-1:0]      blocks_ext;
    fpba_cmp_t             verdict;

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign accept        = req.valid && req.ready;
    assign publish       = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);
    assign slot_in_range = (32'(req.slot_index) < 32'(NUM_BLOCKS));
    assign in_size       = SIZE_BITS'(req.size_value);
    // a never-loaded entry reads as zero
    assign entry_val     = rd_vld_reg ? rd_data_reg : '0;
    assign last_entry    = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign remain        = pick_val_reg - size_reg;
    assign blocks_ext    = CMP_W'(blocks_reg);

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.chosen_block = out_block_reg;
    assign rsp.space_left   = out_left_reg;

    fpba_fit_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .entry_val (entry_val),
        .req_size  (size_reg),
        .pick_val  (pick_val_reg),
        .found     (found_reg),
        .mode      (fit_mode_reg),
        .verdict   (verdict)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        size_next       = size_reg;
        pick_next       = pick_reg;
        pick_val_next   = pick_val_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_left_next   = res_left_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = pick_reg;
        wr_data         = remain;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    size_next     = in_size;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    if (req.req_type == REQ_LOAD)
                    begin
                        wr_en           = slot_in_range;
                        wr_addr         = IDX_W'(req.slot_index);
                        wr_data         = in_size;
                        res_status_next = STAT_LOADED;
                        res_block_next  = req.slot_index;
                        res_left_next   = slot_in_range ? SIZE_W'(in_size) : '0;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        // saturate the search count to the table depth
                        count_next = (blocks_ext > CMP_W'(NUM_BLOCKS)) ?
                                     CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_reg);
                        state_next = (blocks_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr = scan_idx_reg + IDX_W'(1);
                if (verdict.take)
                begin
                    found_next    = 1'b1;
                    pick_next     = scan_idx_reg;
                    pick_val_next = entry_val;
                end
                if (verdict.stop || last_entry)
                    state_next = ST_WRITE;
                else
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            ST_WRITE:
            begin
                wr_en = found_reg;
                if (found_reg)
                begin
                    res_status_next = STAT_ALLOCATED;
                    res_block_next  = SLOT_W'(pick_reg);
                    res_left_next   = SIZE_W'(remain);
                end
                else
                begin
                    res_status_next = STAT_NO_FIT;
                    res_block_next  = '0;
                    res_left_next   = '0;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (publish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !rsp.ready) || publish;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fit_mode_reg  <= FIT_MODE_RESET;
            blocks_reg    <= BLOCKS_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FIT_MODE:      fit_mode_reg <= cfg.data[MODE_W-1:0];
                    CFG_BLOCKS_IN_USE: blocks_reg   <= cfg.data[BLK_CNT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        pick_reg       <= pick_next;
        pick_val_reg   <= pick_val_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_left_reg   <= res_left_next;
        if (publish)
        begin
            out_status_reg <= res_status_reg;
            out_block_reg  <= res_block_reg;
            out_left_reg   <= res_left_reg;
        end
    end

    // The scan never runs past the saturated search count
    `ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, CNT_W'(scan_idx_reg) < count_reg, "scan index beyond search count")
    // A held pick always satisfies the request
    `ASSERT_IMPLIES(a_pick_fits, clk, rst_n, (state_reg == ST_WRITE) && found_reg, pick_val_reg >= size_reg, "picked block too small")
    // A result only appears out of the finish state
    `ASSERT_IMPLIES(a_publish_src, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FIN, "result raised outside finish")
    // A stalled result is never overwritten
    `ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid_reg && !rsp.ready, $stable(out_left_reg) && $stable(out_status_reg), "pending result overwritten")

endmodule

[sv/fpba_fit_cmp.sv]
// Shared compare unit: judges one table entry against the request and pick.
// Depends on fpba_pkg.
module fpba_fit_cmp #(
    parameter int SIZE_BITS = 16
) (
    input  logic [SIZE_BITS-1:0]      entry_val,
    input  logic [SIZE_BITS-1:0]      req_size,
    input  logic [SIZE_BITS-1:0]      pick_val,
    input  logic                      found,
    input  logic [fpba_pkg::MODE_W-1:0] mode,
    output fpba_pkg::fpba_cmp_t       verdict
);
    import fpba_pkg::*;

    logic fits;
    logic better;

    always_comb
    begin
        fits   = (entry_val >= req_size);
        case (mode)
            MODE_BEST:  better = (entry_val < pick_val);
            MODE_WORST: better = (entry_val > pick_val);
            default:    better = 1'b0;
        endcase
        verdict.take = fits && (!found || better);
        // anything but best or worst fit ends on the first entry that fits
        verdict.stop = fits && (mode != MODE_BEST) && (mode != MODE_WORST);
    end
endmodule

[tb/fit_policy_block_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of fit_policy_block_allocator_unit: directed and random traffic
// on the request, result and register channels, checked against a local allocation model.
// Depends on fpba_pkg, the fpba_in_if/fpba_out_if/fpba_cfg_if interfaces and the RTL top.
module fit_policy_block_allocator_unit_tb;
    import fpba_pkg::*;

    localparam int BLOCKS         = 8;
    localparam int SIZE_BITS      = 16;
    localparam int RANDOM_ITEMS   = 1830;
    localparam int RANDOM_PHASES  = 12;
    // A healthy run never goes this long without some item moving on a channel:
    // longest sender gap + longest receiver stall + one full search of the table.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    // Mode code 3 has no name in the package; it must behave as first fit.
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    // Register index with no register behind it; writes to it change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   block;
        logic [SIZE_W-1:0]   left;
    } alloc_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fpba_in_if  req_ch ();
    fpba_out_if rsp_ch ();
    fpba_cfg_if cfg_ch ();

    fit_policy_block_allocator_unit #(
        .NUM_BLOCKS (BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #10 clk = ~clk;

    // Local copy of the allocator: free-space table and both registers.
    logic [SIZE_W-1:0]    free_model [BLOCKS];
    logic [MODE_W-1:0]    mode_model  = FIT_MODE_RESET;
    logic [BLK_CNT_W-1:0] count_model = BLOCKS_RESET;

    alloc_result_t expected_results [$];
    int            fails        = 0;
    int            idle_cycles  = 0;
    int            stall_left   = 0;
    bit            gaps_on      = 1'b1;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Apply one request to the local table and return the result it must give.
    function automatic alloc_result_t allocate_in_model(logic [REQ_TYPE_W-1:0] kind,
                                                        logic [SLOT_W-1:0]     slot,
                                                        logic [SIZE_W-1:0]     size);
        alloc_result_t res;
        int            span;
        int            pick;
        bit            found;
        bit            done;
        if (kind == REQ_LOAD) begin
            // slot is 3 bits wide and the table has 8 entries, so every load lands
            free_model[slot] = size;
            res.status = STAT_LOADED;
            res.block  = slot;
            res.left   = size;
            return res;
        end
        // Saturate the search range to the table size; zero searches nothing.
        span  = (count_model > BLOCKS) ? BLOCKS : count_model;
        pick  = 0;
        found = 1'b0;
        done  = 1'b0;
        for (int j = 0; j < span; j++) begin
            if (!done && free_model[j] >= size) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = j;
                    // first fit, and the spare mode code, stop at the first hit
                    if (mode_model != MODE_BEST && mode_model != MODE_WORST)
                        done = 1'b1;
                end else if (mode_model == MODE_BEST && free_model[j] < free_model[pick]) begin
                    pick = j;
                end else if (mode_model == MODE_WORST && free_model[j] > free_model[pick]) begin
                    pick = j;
                end
            end
        end
        if (!found) begin
            res.status = STAT_NO_FIT;
            res.block  = '0;
            res.left   = '0;
            return res;
        end
        // A zero-size request fits even an empty block and leaves it as it is.
        free_model[pick] = free_model[pick] - size;
        res.status = STAT_ALLOCATED;
        res.block  = pick[SLOT_W-1:0];
        res.left   = free_model[pick];
        return res;
    endfunction

    // Offer one request item after a random gap and hold it until accepted.
    // Valid is left high on return, so back-to-back items never lower and
    // raise it within the same time step.
    task automatic send_item(logic [REQ_TYPE_W-1:0] kind,
                             logic [SLOT_W-1:0]     slot,
                             logic [SIZE_W-1:0]     size);
        int gap;
        gap = pick_gap();
        cfg_ch.valid <= 1'b0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.slot_index <= slot;
        req_ch.size_value <= size;
        do @(posedge clk); while (!req_ch.ready);
        expected_results.push_back(allocate_in_model(kind, slot, size));
    endtask

    // Drop the request valid and wait until every expected result has come back.
    // Each item gives exactly one result, so an empty store means an idle block.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_FIT_MODE)
            mode_model = val[MODE_W-1:0];
        else if (idx == CFG_BLOCKS_IN_USE)
            count_model = val;
    endtask

    // Result side: check each accepted item, then decide whether to stall.
    always @(posedge clk) begin
        alloc_result_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d block %0d left %0h",
                             $time, rsp_ch.status, rsp_ch.chosen_block, rsp_ch.space_left);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        fails++;
                    end
                    if (rsp_ch.chosen_block !== want.block) begin
                        $display("%0t: chosen_block expected %0d actual %0d",
                                 $time, want.block, rsp_ch.chosen_block);
                        fails++;
                    end
                    if (rsp_ch.space_left !== want.left) begin
                        $display("%0t: space_left expected %0h actual %0h",
                                 $time, want.left, rsp_ch.space_left);
                        fails++;
                    end
                end
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if no channel moves an item for too long.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Right after reset the table is empty: a nonzero request cannot fit, a zero
    // request fits block 0 and leaves it empty.
    task automatic test_reset_table();
        send_item(REQ_ALLOC, 3'd5, 16'h0001);
        send_item(REQ_ALLOC, 3'd2, 16'h0000);
    endtask

    // Load every block, with the size extremes, alternating bit patterns and
    // equal sizes so that ties between blocks can be seen.
    task automatic test_load_extremes();
        send_item(REQ_LOAD, 3'd0, 16'hFFFF);
        send_item(REQ_LOAD, 3'd1, 16'h5555);
        send_item(REQ_LOAD, 3'd2, 16'hAAAA);
        send_item(REQ_LOAD, 3'd3, 16'h0300);
        send_item(REQ_LOAD, 3'd4, 16'h0300);
        send_item(REQ_LOAD, 3'd5, 16'h0200);
        send_item(REQ_LOAD, 3'd6, 16'h0001);
        send_item(REQ_LOAD, 3'd7, 16'hFFFF);
    endtask

    // One or two requests under each placement mode, including the spare code
    // and register data with the upper bits set.
    task automatic test_fit_policies();
        send_item(REQ_ALLOC, 3'd7, 16'h0300);
        write_reg(CFG_FIT_MODE, {2'b00, MODE_BEST});
        send_item(REQ_ALLOC, 3'd0, 16'h0300);
        send_item(REQ_ALLOC, 3'd0, 16'h0001);
        write_reg(CFG_FIT_MODE, {2'b11, MODE_WORST});
        send_item(REQ_ALLOC, 3'd0, 16'h0100);
        send_item(REQ_ALLOC, 3'd0, 16'hFFFF);
        write_reg(CFG_FIT_MODE, {2'b10, MODE_SPARE});
        send_item(REQ_ALLOC, 3'd0, 16'h5000);
    endtask

    // Search range: none, one block, and values above the table size (full table).
    task automatic test_search_range();
        write_reg(CFG_FIT_MODE, {2'b00, MODE_FIRST});
        write_reg(CFG_BLOCKS_IN_USE, 4'd0);
        send_item(REQ_ALLOC, 3'd0, 16'h0000);
        write_reg(CFG_BLOCKS_IN_USE, 4'd1);
        write_reg(CFG_SPARE, 4'hF);
        send_item(REQ_ALLOC, 3'd0, 16'h0001);
        write_reg(CFG_FIT_MODE, {2'b00, MODE_WORST});
        write_reg(CFG_BLOCKS_IN_USE, 4'd15);
        send_item(REQ_ALLOC, 3'd0, 16'h0010);
        write_reg(CFG_BLOCKS_IN_USE, 4'd9);
        send_item(REQ_ALLOC, 3'd0, 16'h0010);
    endtask

    // Random traffic in phases, each with its own register setting. Loads keep
    // the table stocked; request sizes mostly derive from the table so that
    // exact fits, near misses and ties come up often.
    task automatic test_random_traffic();
        int                    r;
        int                    per_phase;
        logic [SLOT_W-1:0]     slot;
        logic [SIZE_W-1:0]     size;
        logic [SIZE_W-1:0]     base;
        logic [BLK_CNT_W-1:0]  span;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                span = BLK_CNT_W'($urandom_range(1, BLOCKS));
            else if (r < 85)
                span = BLK_CNT_W'(BLOCKS);
            else if (r < 90)
                span = '0;
            else
                span = BLK_CNT_W'($urandom_range(BLOCKS + 1, 15));
            write_reg(CFG_FIT_MODE, CFG_DATA_W'($urandom_range(0, 15)));
            write_reg(CFG_BLOCKS_IN_USE, span);
            // one phase runs with no gaps on either side
            gaps_on = (p != RANDOM_PHASES / 2);
            for (int i = 0; i < per_phase; i++) begin
                slot = SLOT_W'($urandom_range(0, BLOCKS - 1));
                if ($urandom_range(0, 99) < 35) begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        size = SIZE_W'(16'h0100 * $urandom_range(1, 3));
                    else if (r < 25)
                        size = 16'hFFFF;
                    else if (r < 35)
                        size = 16'h0000;
                    else
                        size = SIZE_W'($urandom_range(0, 16'hFFFF));
                    send_item(REQ_LOAD, slot, size);
                end else begin
                    base = free_model[$urandom_range(0, BLOCKS - 1)];
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        size = base;
                    else if (r < 60)
                        size = SIZE_W'($urandom_range(0, base));
                    else if (r < 75)
                        size = base + 16'd1;
                    else if (r < 85)
                        size = 16'h0000;
                    else
                        size = SIZE_W'($urandom_range(0, 16'hFFFF));
                    send_item(REQ_ALLOC, slot, size);
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int k = 0; k < BLOCKS; k++)
            free_model[k] = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOAD;
        req_ch.slot_index = '0;
        req_ch.size_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_FIT_MODE;
        cfg_ch.data       = '0;

        // Hold reset from the start, then release it on a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_table();
        test_load_extremes();
        test_fit_policies();
        test_search_range();
        test_random_traffic();

        // Drain: everything back, then a further wait to catch stray results.
        settle();
        cfg_ch.valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            $display("%0t: results expected %0d actual 0",
                     $time, expected_results.size());
        if (fails == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
